>>> sv/manifest_version_checksum_checker_macros.svh
// assertion macros for the manifest version/checksum checker
// no dependencies; included by the top level only
`ifndef MANIFEST_VERSION_CHECKSUM_CHECKER_MACROS_SVH
`define MANIFEST_VERSION_CHECKSUM_CHECKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MVC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define MVC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mvc_pkg.sv
// shared types and constants for the manifest version/checksum checker
// no dependencies
package mvc_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 64;

  // register indexes (byte address bit 3 selects)
  localparam logic REG_EXP_VERSION  = 1'b0;
  localparam logic REG_EXP_CHECKSUM = 1'b1;

  // characters of the grammar
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;

  typedef enum logic [3:0] {
    PH_V     = 4'd0,
    PH_VEQ   = 4'd1,
    PH_VDIG1 = 4'd2,
    PH_VDIG  = 4'd3,
    PH_C     = 4'd4,
    PH_CEQ   = 4'd5,
    PH_CDIG1 = 4'd6,
    PH_CDIG  = 4'd7,
    PH_DONE  = 4'd8,
    PH_ERR   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_FORMAT = 2'd1,
    ST_VER_MISM   = 2'd2,
    ST_CHK_MISM   = 2'd3
  } status_e;

  typedef struct packed {
    logic [VAL_W-1:0] expected_version;
    logic [VAL_W-1:0] expected_checksum;
  } cfg_t;

endpackage

>>> sv/mvc_cfg_regs.sv
// apb-style register file holding the expected version and checksum
// depends on mvc_pkg
module mvc_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvc_pkg::ADDR_W-1:0] paddr,
  input  logic [mvc_pkg::DATA_W-1:0] pwdata,
  output logic [mvc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mvc_pkg::cfg_t              cfg_o
);
  import mvc_pkg::*;

  logic [VAL_W-1:0] exp_ver_q, exp_chk_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q <= '0;
      exp_chk_q <= '0;
    end else if (wr_en) begin
      case (paddr[3])
        REG_EXP_VERSION:  exp_ver_q <= pwdata;
        REG_EXP_CHECKSUM: exp_chk_q <= pwdata;
        default:          exp_ver_q <= exp_ver_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_EXP_VERSION:  prdata = exp_ver_q;
      REG_EXP_CHECKSUM: prdata = exp_chk_q;
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.expected_version  = exp_ver_q;
  assign cfg_o.expected_checksum = exp_chk_q;

endmodule

>>> sv/mvc_parser.sv
// grammar state, decimal accumulators and status decision for one byte a cycle while step_i is high
// depends on mvc_pkg
module mvc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  mvc_pkg::cfg_t     cfg_i,
  output mvc_pkg::status_e  status_o
);
  import mvc_pkg::*;

  phase_e           phase_q, phase_d, phase_n;
  logic [VAL_W-1:0] ver_q, ver_d, ver_n;
  logic [VAL_W-1:0] chk_q, chk_d, chk_n;
  logic [LEN_W-1:0] len_q, len_d, len_n;
  logic             ended_q, ended_d, ended_n;

  logic             is_digit, in_ver;
  logic [3:0]       diff;
  logic [VAL_W-1:0] acc;
  logic [VAL_W+3:0] prod;
  logic             ovf;

  // shared multiply-by-ten accumulate: acc*8 + acc*2 + digit
  assign is_digit = (byte_i >= CH_DIG0) && (byte_i <= CH_DIG9);
  // low nibble of an ascii digit is its value
  assign diff     = byte_i[3:0];
  assign in_ver   = (phase_q == PH_VDIG1) || (phase_q == PH_VDIG);
  assign acc      = in_ver ? ver_q : chk_q;
  assign prod     = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {64'b0, diff};
  assign ovf      = |prod[VAL_W+3:VAL_W];

  always_comb begin
    phase_n = phase_q;
    ver_n   = ver_q;
    chk_n   = chk_q;
    len_n   = len_q;
    ended_n = ended_q;
    if (!ended_q) begin
      if (byte_i == CH_NUL) begin
        ended_n = 1'b1;
      end else begin
        if (len_q != LEN_W'(MAX_LEN)) len_n = len_q + 1'b1;
        case (phase_q)
          PH_V:   phase_n = (byte_i == CH_V)  ? PH_VEQ   : PH_ERR;
          PH_VEQ: phase_n = (byte_i == CH_EQ) ? PH_VDIG1 : PH_ERR;
          PH_C:   phase_n = (byte_i == CH_C)  ? PH_CEQ   : PH_ERR;
          PH_CEQ: phase_n = (byte_i == CH_EQ) ? PH_CDIG1 : PH_ERR;
          PH_VDIG1, PH_VDIG: begin
            if (is_digit) begin
              phase_n = ovf ? PH_ERR : PH_VDIG;
              ver_n   = prod[VAL_W-1:0];
            end else if (phase_q == PH_VDIG && byte_i == CH_SPACE) begin
              phase_n = PH_C;
            end else begin
              phase_n = PH_ERR;
            end
          end
          PH_CDIG1, PH_CDIG: begin
            if (is_digit) begin
              phase_n = ovf ? PH_ERR : PH_CDIG;
              chk_n   = prod[VAL_W-1:0];
            end else if (phase_q == PH_CDIG && byte_i == CH_NL) begin
              phase_n = PH_DONE;
            end else begin
              phase_n = PH_ERR;
            end
          end
          default: phase_n = PH_ERR;
        endcase
      end
    end
  end

  always_comb begin
    if (len_n == LEN_W'(MAX_LEN) || phase_n != PH_DONE) begin
      status_o = ST_BAD_FORMAT;
    end else if (ver_n != cfg_i.expected_version) begin
      status_o = ST_VER_MISM;
    end else if (chk_n != cfg_i.expected_checksum) begin
      status_o = ST_CHK_MISM;
    end else begin
      status_o = ST_OK;
    end
  end

  // clear for the next manifest after the last byte
  always_comb begin
    phase_d = phase_q;
    ver_d   = ver_q;
    chk_d   = chk_q;
    len_d   = len_q;
    ended_d = ended_q;
    if (step_i) begin
      if (last_i) begin
        phase_d = PH_V;
        ver_d   = '0;
        chk_d   = '0;
        len_d   = '0;
        ended_d = 1'b0;
      end else begin
        phase_d = phase_n;
        ver_d   = ver_n;
        chk_d   = chk_n;
        len_d   = len_n;
        ended_d = ended_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_V;
      ver_q   <= '0;
      chk_q   <= '0;
      len_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      ver_q   <= ver_d;
      chk_q   <= chk_d;
      len_q   <= len_d;
      ended_q <= ended_d;
    end
  end

endmodule

>>> sv/manifest_version_checksum_checker.sv
// a byte marked last passes the input register, then shows its status from the status register
// one byte per cycle while no last byte is held; set by the combinational parse and accumulate step
// a last byte waits in the input register only while the status register is held
// reset: asynchronous active low; parser returns to expect-v, expected values clear
// depends on mvc_pkg, mvc_cfg_regs, mvc_parser and the assertion macro header
`include "manifest_version_checksum_checker_macros.svh"
module manifest_version_checksum_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       is_last_i,
  // status channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mvc_pkg::ADDR_W-1:0] paddr,
  input  logic [mvc_pkg::DATA_W-1:0] pwdata,
  output logic [mvc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import mvc_pkg::*;

  cfg_t       cfg;
  status_e    status_c;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;

  logic       in_accept, out_free, advance;

  // a status slot is free when empty or being taken this cycle
  assign out_free  = !out_valid_q || !out_stall_i;
  // non-last bytes never need the status slot
  assign advance   = in_valid_q && (!last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)    in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload holds while stalled, loads on accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= text_byte_i;
      last_q <= is_last_i;
    end
  end

  mvc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mvc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .cfg_i    (cfg),
    .status_o (status_c)
  );

  // status is captured only for a last byte
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    if (advance && last_q) begin
      out_valid_d = 1'b1;
      status_d    = status_c;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // a processed last byte always leaves a status behind
  `MVC_ASSERT_NEXT(a_last_gives_status, clk_i, rst_ni, advance && last_q, out_valid_o, "last byte produced no status")
  // only a held last byte may back-pressure the byte channel
  `MVC_ASSERT_NOW(a_stall_only_on_last, clk_i, rst_ni, in_stall_o, in_valid_q && last_q && out_valid_q, "stall without a waiting last byte")
  // a non-last byte never takes a status slot
  `MVC_ASSERT_NEXT(a_no_spurious_status, clk_i, rst_ni, !out_valid_o && !(advance && last_q), !out_valid_o, "status without a last byte")

endmodule
